// ===== rtl/tos_pkg.sv =====
// Shared types and constants for the track occupancy scanner.
// Used by the controller, the datapath and the top level; depends on nothing.
package tos_pkg;

    // Default number of scanned feedback channels.
    localparam int CHANNELS_DEF = 16;

    // Fixed widths of the transaction fields.
    localparam int FUNC_W    = 2;
    localparam int ID_W      = 8;
    localparam int CHAN_W    = 4;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 8;

    // Function codes of an input transaction.
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUSY_UPPER   = 2'd1;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] WINDOW_LIMIT_RST = 8'd50;
    localparam logic [CFG_W-1:0] BUSY_UPPER_RST   = 8'd45;

    // Per-channel statistics word held in the statistics RAM.
    typedef struct packed {
        logic               occ;
        logic [COUNT_W-1:0] high;
        logic [COUNT_W-1:0] ticks;
    } stat_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic tick_rd;
        logic tick_eval;
        logic q_start;
        logic q_step;
        logic set_wr;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic q_match;
        logic q_last;
        logic out_busy;
    } sts_t;

    // Contact map entry after reset: channel index plus one.
    function automatic logic [ID_W-1:0] map_reset(input logic [ID_W-1:0] idx);
        return idx + 8'd1;
    endfunction

endpackage

// ===== rtl/track_occupancy_scanner.sv =====
// Track occupancy scanner: scans CHANNELS feedback inputs one tick at a time,
// judges each channel free or occupied over a tick window, and reports state
// changes and contact id lookups. A tick transaction reads the RAMs, then
// evaluates and writes back. A status query reads one contact map entry per
// cycle from channel 0 upward while the output register is free, and stops
// at the first match or the last channel. A set transaction writes the map. A
// result waits in an output register, and the next transaction is accepted
// while it waits. Every tick evaluation and every query compare step holds
// until that result is taken, whether or not it would produce a new result, so
// a stalled output adds its full wait to the next tick or query. Configuration
// writes are taken every cycle. No clearing pass is needed after reset.
// Depends on tos_pkg, tos_ctrl, tos_dp and tos_ram.
module track_occupancy_scanner
    import tos_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [FUNC_W-1:0]    func,
    input  logic                 sample,
    input  logic [ID_W-1:0]      contact_id,
    input  logic [CHAN_W-1:0]    channel,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CHAN_W-1:0]    channel_res,
    output logic [ID_W-1:0]      contact_id_res,
    output logic                 new_state,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    tos_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .sts      (sts),
        .cmd      (cmd)
    );

    tos_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .sample         (sample),
        .contact_id     (contact_id),
        .channel        (channel),
        .cfg_wr         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .channel_res    (channel_res),
        .contact_id_res (contact_id_res),
        .new_state      (new_state)
    );

endmodule

// ===== rtl/tos_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; used for the statistics store and the contact map.
module tos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/tos_ctrl.sv =====
// Controller state machine of the track occupancy scanner.
// Depends on tos_pkg; drives the datapath through cmd_t and reads sts_t.
module tos_ctrl
    import tos_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FUNC_W-1:0] func,
    input  sts_t              sts,
    output cmd_t              cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK_EVAL,
        S_Q_CHK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // Command decode and next state.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cmd.accept = accept;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        FUNC_TICK:
                        begin
                            cmd.tick_rd = 1'b1;
                            state_next  = S_TICK_EVAL;
                        end
                        FUNC_QUERY:
                        begin
                            cmd.q_start = 1'b1;
                            state_next  = S_Q_CHK;
                        end
                        FUNC_SET:
                        begin
                            cmd.set_wr = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_TICK_EVAL:
            begin
                // Hold while an earlier result still sits in the output register.
                if (!sts.out_busy)
                begin
                    cmd.tick_eval = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_Q_CHK:
            begin
                if (!sts.out_busy)
                begin
                    cmd.q_step = 1'b1;
                    if (sts.q_match || sts.q_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A result is never produced while the output register is still full.
    a_no_emit_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.tick_eval || cmd.q_step) |-> !sts.out_busy)
        else $error("evaluation issued while output register is busy");

    // An accepted tick always goes on to its evaluation cycle.
    a_tick_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == FUNC_TICK) |=> state_reg == S_TICK_EVAL)
        else $error("tick transaction did not reach evaluation");

    // A query ends on the first match.
    a_query_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.q_step && sts.q_match) |=> state_reg == S_IDLE)
        else $error("query kept scanning after a match");

    // The controller is ready again in the cycle after a tick evaluation.
    a_eval_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick_eval |=> in_ready)
        else $error("controller did not return to idle after a tick");

endmodule

// ===== rtl/tos_dp.sv =====
// Datapath of the track occupancy scanner: configuration registers, scan
// pointer, statistics and contact map RAMs, query index and result register.
// Depends on tos_pkg and tos_ram.
module tos_dp
    import tos_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic                 sample,
    input  logic [ID_W-1:0]      contact_id,
    input  logic [CHAN_W-1:0]    channel,
    input  logic                 cfg_wr,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CHAN_W-1:0]    channel_res,
    output logic [ID_W-1:0]      contact_id_res,
    output logic                 new_state
);

    localparam int AW = $clog2(CHANNELS);
    localparam logic [AW-1:0] LAST_CH = AW'(CHANNELS - 1);

    logic [CFG_W-1:0]  window_limit_reg;
    logic [CFG_W-1:0]  busy_upper_reg;
    logic [AW-1:0]     ptr_reg;
    logic [AW-1:0]     qidx_reg;
    logic              sample_reg;
    logic [ID_W-1:0]   id_reg;
    logic [CHANNELS-1:0] stat_vld_reg;
    logic [CHANNELS-1:0] map_vld_reg;

    logic              out_valid_reg;
    logic [CHAN_W-1:0] out_chan_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic              out_state_reg;

    stat_t             stat_rdata;
    stat_t             stat_cur;
    stat_t             stat_wdata;
    logic [ID_W-1:0]   map_rdata;
    logic              map_we;
    logic [AW-1:0]     map_waddr;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;

    logic [ID_W-1:0]    tick_map;
    logic [ID_W-1:0]    q_map;
    logic               q_occ;
    logic [COUNT_W-1:0] ticks_inc;
    logic [COUNT_W-1:0] high_inc;
    logic               window_done;
    logic               busy;
    logic               tick_event;
    logic               q_advance;
    logic               set_in_range;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_limit_reg <= WINDOW_LIMIT_RST;
            busy_upper_reg   <= BUSY_UPPER_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                REG_WINDOW_LIMIT: window_limit_reg <= cfg_data;
                REG_BUSY_UPPER:   busy_upper_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Latch the payload of an accepted transaction.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= sample;
            id_reg     <= contact_id;
        end
    end

    // Entries never written read as their reset values.
    assign stat_cur = stat_vld_reg[ptr_reg] ? stat_rdata : '0;
    assign tick_map = map_vld_reg[ptr_reg] ? map_rdata : map_reset(ID_W'(ptr_reg));
    assign q_map    = map_vld_reg[qidx_reg] ? map_rdata : map_reset(ID_W'(qidx_reg));
    assign q_occ    = stat_vld_reg[qidx_reg] ? stat_rdata.occ : 1'b0;

    // Tick evaluation: bump counts, judge the channel once its window closes.
    assign ticks_inc   = stat_cur.ticks + 8'd1;
    assign high_inc    = stat_cur.high + COUNT_W'(sample_reg);
    assign window_done = (ticks_inc > window_limit_reg);
    assign busy        = (high_inc != '0) && (high_inc < busy_upper_reg);
    assign tick_event  = cmd.tick_eval && window_done && (busy != stat_cur.occ);

    always_comb
    begin
        if (window_done)
        begin
            stat_wdata       = '0;
            stat_wdata.occ   = busy;
        end
        else
        begin
            stat_wdata.occ   = stat_cur.occ;
            stat_wdata.high  = high_inc;
            stat_wdata.ticks = ticks_inc;
        end
    end

    // Query scan: compare one entry per cycle unless stalled, prefetch next.
    assign sts.q_match  = (q_map == id_reg);
    assign sts.q_last   = (qidx_reg == LAST_CH);
    assign sts.out_busy = out_valid_reg && !out_ready;
    assign q_advance    = cmd.q_step && !sts.q_match && !sts.q_last;

    // Shared read address for both RAMs.
    assign rd_en = cmd.tick_rd || cmd.q_start || q_advance;
    always_comb
    begin
        if (cmd.tick_rd)
        begin
            rd_addr = ptr_reg;
        end
        else if (cmd.q_start)
        begin
            rd_addr = '0;
        end
        else
        begin
            rd_addr = qidx_reg + AW'(1);
        end
    end

    // Map writes from set transactions within the channel range.
    assign set_in_range = (32'(channel) < CHANNELS);
    assign map_we       = cmd.set_wr && set_in_range;
    assign map_waddr    = AW'(channel);

    tos_ram #(
        .WIDTH ($bits(stat_t)),
        .DEPTH (CHANNELS)
    ) u_stat_ram (
        .clk   (clk),
        .we    (cmd.tick_eval),
        .waddr (ptr_reg),
        .wdata (stat_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (stat_rdata)
    );

    tos_ram #(
        .WIDTH (ID_W),
        .DEPTH (CHANNELS)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (contact_id),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (map_rdata)
    );

    // Scan pointer, query index and entry valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg      <= '0;
            qidx_reg     <= '0;
            stat_vld_reg <= '0;
            map_vld_reg  <= '0;
        end
        else
        begin
            if (cmd.tick_eval)
            begin
                ptr_reg               <= (ptr_reg == LAST_CH) ? '0 : ptr_reg + AW'(1);
                stat_vld_reg[ptr_reg] <= 1'b1;
            end
            if (cmd.q_start)
            begin
                qidx_reg <= '0;
            end
            else if (q_advance)
            begin
                qidx_reg <= qidx_reg + AW'(1);
            end
            if (map_we)
            begin
                map_vld_reg[map_waddr] <= 1'b1;
            end
        end
    end

    // Output register: filled by a state change or a query hit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (tick_event || (cmd.q_step && sts.q_match))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_event)
        begin
            out_chan_reg  <= CHAN_W'(ptr_reg);
            out_id_reg    <= tick_map;
            out_state_reg <= busy;
        end
        else if (cmd.q_step && sts.q_match)
        begin
            out_chan_reg  <= CHAN_W'(qidx_reg);
            out_id_reg    <= q_map;
            out_state_reg <= q_occ;
        end
    end

    assign out_valid      = out_valid_reg;
    assign channel_res    = out_chan_reg;
    assign contact_id_res = out_id_reg;
    assign new_state      = out_state_reg;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the track occupancy scanner: drives scan ticks,
// status queries and map writes, predicts state-change and lookup reports.
// Depends on tos_pkg and the track_occupancy_scanner top level.
module tb;
    import tos_pkg::*;

    localparam int CHANNELS      = CHANNELS_DEF;
    localparam int SETTLE_CYCLES = 2 * CHANNELS + 8;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SHOW_LIMIT    = 10;

    // The one function code that the block does not define.
    localparam logic [FUNC_W-1:0] FUNC_RSVD = 2'd3;

    // One expected report: channel, its contact id and its state.
    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [ID_W-1:0]   id;
        logic              state;
    } report_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [FUNC_W-1:0]    func = FUNC_TICK;
    logic                 sample = 1'b0;
    logic [ID_W-1:0]      contact_id = '0;
    logic [CHAN_W-1:0]    channel = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [CHAN_W-1:0]    channel_res;
    logic [ID_W-1:0]      contact_id_res;
    logic                 new_state;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_WINDOW_LIMIT;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Scanner state as the testbench expects it.
    logic [CFG_W-1:0]   window_lim;
    logic [CFG_W-1:0]   busy_up;
    logic [CHAN_W-1:0]  scan_ptr;
    logic [COUNT_W-1:0] tick_cnt [CHANNELS];
    logic [COUNT_W-1:0] high_cnt [CHANNELS];
    logic               occ      [CHANNELS];
    logic [ID_W-1:0]    id_map   [CHANNELS];

    report_t report_q [$];

    int send_idle_pct = 36;
    int recv_idle_pct = 86;
    int hold_req      = 0;
    int hold_left     = 0;
    int err_count     = 0;
    int shown         = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int cfg_writes    = 0;
    int cycle_count   = 0;

    track_occupancy_scanner u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .sample         (sample),
        .contact_id     (contact_id),
        .channel        (channel),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .channel_res    (channel_res),
        .contact_id_res (contact_id_res),
        .new_state      (new_state),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #6 clk = ~clk;

    // Run length guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold when a test asks for one.
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left--;
        end
        else
            out_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare every accepted result with the oldest expected report.
    always @(posedge clk)
    begin : result_check
        report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (report_q.size() == 0)
            begin
                err_count++;
                if (shown < SHOW_LIMIT)
                begin
                    shown++;
                    $display("unexpected result: ch %0d id %0d state %0d",
                             channel_res, contact_id_res, new_state);
                end
            end
            else
            begin
                want = report_q.pop_front();
                if (want.chan !== channel_res || want.id !== contact_id_res ||
                    want.state !== new_state)
                begin
                    err_count++;
                    if (shown < SHOW_LIMIT)
                    begin
                        shown++;
                        $display("mismatch: expected ch %0d id %0d state %0d,",
                                 want.chan, want.id, want.state);
                        $display("          got ch %0d id %0d state %0d",
                                 channel_res, contact_id_res, new_state);
                    end
                end
            end
        end
    end

    // Put the expected scanner state back to its reset values.
    function automatic void reset_scanner();
        int i;
        window_lim = WINDOW_LIMIT_RST;
        busy_up    = BUSY_UPPER_RST;
        scan_ptr   = '0;
        for (i = 0; i < CHANNELS; i++)
        begin
            tick_cnt[i] = '0;
            high_cnt[i] = '0;
            occ[i]      = 1'b0;
            id_map[i]   = ID_W'(i + 1);
        end
    endfunction

    // Advance the expected state by one accepted transaction and queue any report.
    function automatic void scan_step(input logic [FUNC_W-1:0] f, input logic s,
                                      input logic [ID_W-1:0] id,
                                      input logic [CHAN_W-1:0] ch);
        int   i;
        logic busy;
        logic found;
        logic [CHAN_W-1:0] p;
        p = scan_ptr;
        case (f)
            FUNC_TICK:
            begin
                if (s)
                    high_cnt[p] = high_cnt[p] + 1'b1;
                tick_cnt[p] = tick_cnt[p] + 1'b1;
                // Window complete: judge the channel and clear its counts.
                if (tick_cnt[p] > window_lim)
                begin
                    busy = (high_cnt[p] != '0) && (high_cnt[p] < busy_up);
                    if (busy != occ[p])
                    begin
                        occ[p] = busy;
                        report_q.push_back('{chan: p, id: id_map[p], state: busy});
                    end
                    tick_cnt[p] = '0;
                    high_cnt[p] = '0;
                end
                scan_ptr = (p == CHAN_W'(CHANNELS - 1)) ? '0 : p + 1'b1;
            end
            FUNC_QUERY:
            begin
                // Lowest matching channel wins.
                found = 1'b0;
                for (i = 0; i < CHANNELS; i++)
                begin
                    if (!found && id_map[i] == id)
                    begin
                        found = 1'b1;
                        report_q.push_back('{chan: CHAN_W'(i), id: id_map[i],
                                             state: occ[i]});
                    end
                end
            end
            FUNC_SET:
            begin
                if (ch < CHANNELS)
                    id_map[ch] = id;
            end
            default:
            begin
            end
        endcase
    endfunction

    // Offer one transaction after a random gap; returns just after the falling edge.
    task automatic send_item(input logic [FUNC_W-1:0] f, input logic s,
                             input logic [ID_W-1:0] id, input logic [CHAN_W-1:0] ch);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        func       = f;
        sample     = s;
        contact_id = id;
        channel    = ch;
        do
            @(posedge clk);
        while (!in_ready);
        scan_step(f, s, id, ch);
        items_sent++;
        @(negedge clk);
    endtask

    // Random mix: mostly ticks, with queries that usually hit a mapped id.
    task automatic send_random_item(input int high_pct);
        int pick;
        logic [ID_W-1:0] id;
        pick = $urandom_range(99);
        if (pick < 70)
            send_item(FUNC_TICK, $urandom_range(99) < high_pct, ID_W'($urandom),
                      CHAN_W'($urandom));
        else if (pick < 88)
        begin
            id = ($urandom_range(3) != 0) ? id_map[$urandom_range(CHANNELS - 1)]
                                          : ID_W'($urandom);
            send_item(FUNC_QUERY, 1'($urandom), id, CHAN_W'($urandom));
        end
        else if (pick < 95)
        begin
            id = ($urandom_range(1) != 0) ? ID_W'($urandom_range(31)) : ID_W'($urandom);
            send_item(FUNC_SET, 1'($urandom), id, CHAN_W'($urandom));
        end
        else
            send_item(FUNC_RSVD, 1'($urandom), ID_W'($urandom), CHAN_W'($urandom));
    endtask

    // Let all reports drain and any silent lookup finish.
    task automatic wait_idle();
        in_valid = 1'b0;
        while (report_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_WINDOW_LIMIT)
            window_lim = val;
        else if (idx == REG_BUSY_UPPER)
            busy_up = val;
        cfg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(input logic [CFG_W-1:0] window, input logic [CFG_W-1:0] upper);
        wait_idle();
        write_reg(REG_WINDOW_LIMIT, window);
        write_reg(REG_BUSY_UPPER, upper);
    endtask

    // Lookups on the reset map, rewritten entries, duplicates and the unused code.
    task automatic test_map_lookup();
        send_item(FUNC_QUERY, 1'b0, 8'd1, 4'd0);
        send_item(FUNC_QUERY, 1'b1, 8'd0, 4'hF);
        send_item(FUNC_QUERY, 1'b0, 8'hFF, 4'd7);
        send_item(FUNC_SET, 1'b1, 8'hFF, 4'd15);
        send_item(FUNC_QUERY, 1'b0, 8'hFF, 4'd0);
        send_item(FUNC_SET, 1'b0, 8'd3, 4'd4);
        send_item(FUNC_QUERY, 1'b0, 8'd3, 4'd0);
        send_item(FUNC_SET, 1'b0, 8'd0, 4'd2);
        send_item(FUNC_QUERY, 1'b1, 8'd3, 4'd9);
        send_item(FUNC_QUERY, 1'b0, 8'd0, 4'd0);
        send_item(FUNC_RSVD, 1'b1, 8'hFF, 4'hF);
        send_item(FUNC_SET, 1'b0, 8'h80, 4'd0);
        send_item(FUNC_QUERY, 1'b0, 8'h80, 4'd0);
        send_item(FUNC_TICK, 1'b1, 8'hAA, 4'h5);
        send_item(FUNC_TICK, 1'b0, 8'h55, 4'hA);
        send_item(FUNC_QUERY, 1'b0, 8'd16, 4'd0);
        send_item(FUNC_QUERY, 1'b0, 8'd15, 4'd0);
    endtask

    // Window and busy limits at their extremes.
    task automatic test_config_extremes();
        set_config(8'd0, 8'd255);
        repeat (3) send_item(FUNC_TICK, 1'b1, ID_W'($urandom), CHAN_W'($urandom));
        send_item(FUNC_TICK, 1'b0, ID_W'($urandom), CHAN_W'($urandom));
        set_config(8'd0, 8'd0);
        repeat (3) send_item(FUNC_TICK, 1'b1, ID_W'($urandom), CHAN_W'($urandom));
        set_config(8'd255, 8'd255);
        repeat (2) send_item(FUNC_TICK, 1'b1, ID_W'($urandom), CHAN_W'($urandom));
        set_config(8'd254, 8'd1);
        send_item(FUNC_TICK, 1'b1, ID_W'($urandom), CHAN_W'($urandom));
    endtask

    // Random traffic over several short-window settings.
    task automatic test_random_phase(input int send_pct, input int recv_pct,
                                     input int per_seg);
        int seg;
        int window;
        int upper;
        int high_pct;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (seg = 0; seg < 4; seg++)
        begin
            case ($urandom_range(4))
                0: window = 0;
                1: window = $urandom_range(7, 40);
                default: window = $urandom_range(1, 6);
            endcase
            case ($urandom_range(5))
                0: upper = 255;
                1: upper = $urandom_range(1, 3);
                5: upper = $urandom_range(1, 255);
                default: upper = $urandom_range(1, window + 2);
            endcase
            case ($urandom_range(3))
                0: high_pct = 5;
                1: high_pct = 30;
                2: high_pct = 60;
                default: high_pct = 95;
            endcase
            set_config(CFG_W'(window), CFG_W'(upper));
            repeat (per_seg) send_random_item(high_pct);
        end
    endtask

    // Counts build up with evaluation off, then a short window judges them at once.
    task automatic test_window_wrap();
        set_config(8'd255, 8'd200);
        repeat (200) send_random_item(60);
        set_config(8'd254, 8'd1);
        repeat (30) send_random_item(40);
        set_config(8'd3, CFG_W'($urandom_range(1, 30)));
        repeat (80) send_random_item(50);
    endtask

    // Long receiver hold while ticks keep coming, so the block backs up.
    task automatic test_output_stall();
        set_config(8'd0, 8'd255);
        hold_req = 400;
        repeat (150) send_random_item(50);
    endtask

    initial
    begin
        reset_scanner();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_map_lookup();
        test_config_extremes();
        test_random_phase(36, 86, 55);
        test_random_phase(86, 36, 55);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_window_wrap();
        test_output_stall();
        test_random_phase(0, 0, 50);

        wait_idle();
        $display("Ran %0d transactions with %0d checked results and %0d register writes,",
                 items_sent, results_seen, cfg_writes);
        $display("under random stalls on both sides and one long output hold.");
        if (err_count == 0 && report_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tos_pkg.sv
rtl/tos_ram.sv
rtl/tos_ctrl.sv
rtl/tos_dp.sv
rtl/track_occupancy_scanner.sv
verif/tb.sv
